// File: rtl/vfs_pkg.sv
// shared types, codes and helpers for the fair task scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vfs_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [2:0] OP_SCHED   = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_TASK0    = 3'd1;
    localparam logic [2:0] ERR_NOTFOUND = 3'd2;
    localparam logic [2:0] ERR_FULL     = 3'd3;
    localparam logic [2:0] ERR_EMPTY    = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] task_id;
        logic [15:0] new_task_id;
        logic [15:0] priority_req;
        logic [63:0] current_time;
    } vfs_req_t;

    typedef struct packed {
        logic        running_valid;
        logic [15:0] running_task;
        logic [63:0] running_vruntime;
        logic        task_waiting;
        logic [2:0]  error_code;
    } vfs_rsp_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] weight;
        logic [63:0] vruntime;
    } vfs_entry_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [15:0] divisor;
    } vfs_div_in_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } vfs_div_out_t;

    function automatic logic [15:0] norm_weight(input logic [15:0] w);
        norm_weight = (w == 16'd0) ? 16'd1 : w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/vfs_div.sv
// restoring divider, 64-bit dividend by 16-bit divisor, one quotient bit a cycle
// depends on vfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module vfs_div
    import vfs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire vfs_div_in_t  ctrl,
    output vfs_div_out_t      stat
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[63]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 16'd0;
            quo_next  = ctrl.dividend;
            dvs_next  = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[15:0] : trial[15:0];
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/vruntime_fair_task_scheduler.sv
// fair task scheduler: waiting-task table in a synchronous memory with a
// registered read, running task in registers; depends on vfs_pkg and vfs_div
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    vfs_req_t
//   rsp      out  rsp_valid/rsp_ready    vfs_rsp_t
//
// a request runs a scan of the table memory, an execute step and a second
// scan for the waiting flag
// a schedule with a running task also waits for the bit-serial divider
// one request at a time; req_ready is high only while idle
// a held response stalls the next completion, not the acceptance of a request
// reset clears the valid bits and running task at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module vruntime_fair_task_scheduler
    import vfs_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire vfs_req_t req_data,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output vfs_rsp_t      rsp_data
);

    localparam int AW = $clog2(MAX_TASKS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_DIV  = 6'b000100,
        S_EXEC = 6'b001000,
        S_POST = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    vfs_req_t   req_reg, req_next;
    logic [15:0] w_reg, w_next;

    logic [AW:0]   iss_cnt_reg, iss_cnt_next;
    logic          proc_vld_reg, proc_vld_next;
    logic [AW-1:0] proc_idx_reg, proc_idx_next;

    logic          min_found_reg, min_found_next;
    logic [AW-1:0] min_slot_reg, min_slot_next;
    vfs_entry_t    min_ent_reg, min_ent_next;
    logic          find_found_reg, find_found_next;
    logic [AW-1:0] find_slot_reg, find_slot_next;
    logic [63:0]   find_v_reg, find_v_next;
    logic          free_found_reg, free_found_next;
    logic [AW-1:0] free_slot_reg, free_slot_next;
    logic          wait_found_reg, wait_found_next;

    logic [MAX_TASKS-1:0] valid_reg, valid_next;

    logic        run_valid_reg, run_valid_next;
    logic [15:0] run_id_reg, run_id_next;
    logic [15:0] run_w_reg, run_w_next;
    logic [63:0] run_v_reg, run_v_next;
    logic [63:0] start_reg, start_next;

    logic [2:0]  err_reg, err_next;
    logic        rsp_valid_reg, rsp_valid_next;
    vfs_rsp_t    rsp_reg, rsp_next;

    vfs_entry_t    mem [MAX_TASKS];
    vfs_entry_t    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    vfs_entry_t    wr_data;

    vfs_div_in_t  div_in;
    vfs_div_out_t div_out;

    logic        scan_last;
    logic        cur_valid;
    logic [63:0] vt;
    logic [64:0] sum;
    logic [63:0] base;
    logic [63:0] newv;
    logic        run_wins;
    logic        new_wins;
    logic        run_match;
    vfs_entry_t  run_ent;

    vfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_in),
        .stat  (div_out)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rd_addr   = iss_cnt_reg[AW-1:0];
    assign scan_last = proc_vld_reg && (proc_idx_reg == AW'(MAX_TASKS - 1));
    assign cur_valid = valid_reg[proc_idx_reg];

    assign vt  = (div_out.quotient == 64'd0) ? 64'd1 : div_out.quotient;
    assign sum = {1'b0, run_v_reg} + {1'b0, vt};

    assign base = min_found_reg ? min_ent_reg.vruntime :
                  (run_valid_reg ? run_v_reg : 64'd0);
    assign newv = (base == 64'd0) ? 64'd0 : base - 64'd1;

    // tie with the table minimum goes to the lower slot
    assign run_wins = !min_found_reg || (run_v_reg < min_ent_reg.vruntime) ||
                      (run_v_reg == min_ent_reg.vruntime && free_slot_reg < min_slot_reg);
    assign new_wins = !min_found_reg || (newv < min_ent_reg.vruntime) ||
                      (newv == min_ent_reg.vruntime && free_slot_reg < min_slot_reg);
    assign run_match = run_valid_reg && (run_id_reg == req_reg.task_id);

    assign run_ent.id       = run_id_reg;
    assign run_ent.weight   = run_w_reg;
    assign run_ent.vruntime = run_v_reg;

    always_comb
    begin
        div_in.start    = state_reg == S_SCAN && scan_last &&
                          req_reg.operation == OP_SCHED && run_valid_reg;
        div_in.dividend = req_reg.current_time - start_reg;
        div_in.divisor  = norm_weight(run_w_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        w_next          = w_reg;
        iss_cnt_next    = iss_cnt_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        min_found_next  = min_found_reg;
        min_slot_next   = min_slot_reg;
        min_ent_next    = min_ent_reg;
        find_found_next = find_found_reg;
        find_slot_next  = find_slot_reg;
        find_v_next     = find_v_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        wait_found_next = wait_found_reg;
        valid_next      = valid_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        run_w_next      = run_w_reg;
        run_v_next      = run_v_reg;
        start_next      = start_reg;
        err_next        = err_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_addr         = free_slot_reg;
        wr_data         = run_ent;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        // shared read pipeline for both scans
        if ((state_reg == S_SCAN || state_reg == S_POST) &&
            iss_cnt_reg < (AW + 1)'(MAX_TASKS))
        begin
            iss_cnt_next  = iss_cnt_reg + (AW + 1)'(1);
            proc_vld_next = 1'b1;
            proc_idx_next = iss_cnt_reg[AW-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req_data;
                    w_next          = norm_weight(req_data.priority_req);
                    iss_cnt_next    = '0;
                    min_found_next  = 1'b0;
                    find_found_next = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (proc_vld_reg)
                begin
                    if (cur_valid && (!min_found_reg ||
                                      rd_data_reg.vruntime < min_ent_reg.vruntime))
                    begin
                        min_found_next = 1'b1;
                        min_slot_next  = proc_idx_reg;
                        min_ent_next   = rd_data_reg;
                    end
                    if (cur_valid && !find_found_reg && rd_data_reg.id == req_reg.task_id)
                    begin
                        find_found_next = 1'b1;
                        find_slot_next  = proc_idx_reg;
                        find_v_next     = rd_data_reg.vruntime;
                    end
                    if (!cur_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = proc_idx_reg;
                    end
                end
                if (scan_last)
                    state_next = div_in.start ? S_DIV : S_EXEC;
            end
            S_DIV:
            begin
                if (div_out.done)
                begin
                    // saturating charge
                    run_v_next = sum[64] ? {64{1'b1}} : sum[63:0];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                err_next = ERR_OK;
                case (req_reg.operation)
                    OP_SCHED:
                    begin
                        if (run_valid_reg)
                        begin
                            start_next = req_reg.current_time;
                            if (free_found_reg)
                            begin
                                if (!run_wins)
                                begin
                                    wr_en       = 1'b1;
                                    wr_addr     = free_slot_reg;
                                    wr_data     = run_ent;
                                    valid_next[free_slot_reg] = 1'b1;
                                    valid_next[min_slot_reg]  = 1'b0;
                                    run_id_next = min_ent_reg.id;
                                    run_w_next  = min_ent_reg.weight;
                                    run_v_next  = min_ent_reg.vruntime;
                                end
                            end
                            else if (min_found_reg && min_ent_reg.vruntime < run_v_reg)
                            begin
                                // full table: swap with the minimum
                                wr_en       = 1'b1;
                                wr_addr     = min_slot_reg;
                                wr_data     = run_ent;
                                run_id_next = min_ent_reg.id;
                                run_w_next  = min_ent_reg.weight;
                                run_v_next  = min_ent_reg.vruntime;
                            end
                        end
                        else if (min_found_reg)
                        begin
                            valid_next[min_slot_reg] = 1'b0;
                            run_valid_next = 1'b1;
                            run_id_next    = min_ent_reg.id;
                            run_w_next     = min_ent_reg.weight;
                            run_v_next     = min_ent_reg.vruntime;
                            start_next     = req_reg.current_time;
                        end
                        else
                        begin
                            err_next = ERR_EMPTY;
                        end
                    end
                    OP_ADD:
                    begin
                        if (!free_found_reg)
                        begin
                            err_next = ERR_FULL;
                        end
                        else if (run_valid_reg || !new_wins)
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = free_slot_reg;
                            wr_data.id       = req_reg.task_id;
                            wr_data.weight   = w_reg;
                            wr_data.vruntime = newv;
                            valid_next[free_slot_reg] = 1'b1;
                            if (!run_valid_reg)
                            begin
                                valid_next[min_slot_reg] = 1'b0;
                                run_valid_next = 1'b1;
                                run_id_next    = min_ent_reg.id;
                                run_w_next     = min_ent_reg.weight;
                                run_v_next     = min_ent_reg.vruntime;
                                start_next     = req_reg.current_time;
                            end
                        end
                        else
                        begin
                            // idle and the new task is the minimum: it runs directly
                            run_valid_next = 1'b1;
                            run_id_next    = req_reg.task_id;
                            run_w_next     = w_reg;
                            run_v_next     = newv;
                            start_next     = req_reg.current_time;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (req_reg.task_id == 16'd0)
                        begin
                            err_next = ERR_TASK0;
                        end
                        else if (run_match)
                        begin
                            if (min_found_reg)
                            begin
                                valid_next[min_slot_reg] = 1'b0;
                                run_id_next = min_ent_reg.id;
                                run_w_next  = min_ent_reg.weight;
                                run_v_next  = min_ent_reg.vruntime;
                                start_next  = req_reg.current_time;
                            end
                            else
                            begin
                                run_valid_next = 1'b0;
                                err_next       = ERR_EMPTY;
                            end
                        end
                        else if (find_found_reg)
                        begin
                            valid_next[find_slot_reg] = 1'b0;
                        end
                        else
                        begin
                            err_next = ERR_NOTFOUND;
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (run_match)
                        begin
                            run_id_next = req_reg.new_task_id;
                            run_w_next  = w_reg;
                        end
                        else if (find_found_reg)
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = find_slot_reg;
                            wr_data.id       = req_reg.new_task_id;
                            wr_data.weight   = w_reg;
                            wr_data.vruntime = find_v_reg;
                        end
                        else
                        begin
                            err_next = ERR_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        err_next = ERR_OK;
                    end
                endcase
                iss_cnt_next    = '0;
                wait_found_next = 1'b0;
                state_next      = S_POST;
            end
            S_POST:
            begin
                if (proc_vld_reg && cur_valid && rd_data_reg.id == req_reg.task_id)
                    wait_found_next = 1'b1;
                if (scan_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.running_valid    = run_valid_reg;
                    rsp_next.running_task     = run_valid_reg ? run_id_reg : 16'd0;
                    rsp_next.running_vruntime = run_valid_reg ? run_v_reg : 64'd0;
                    rsp_next.task_waiting     = wait_found_reg;
                    rsp_next.error_code       = err_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_cnt_reg   <= '0;
            proc_vld_reg  <= 1'b0;
            valid_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= 16'd0;
            run_w_reg     <= 16'd1;
            run_v_reg     <= 64'd0;
            start_reg     <= 64'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_cnt_reg   <= iss_cnt_next;
            proc_vld_reg  <= proc_vld_next;
            valid_reg     <= valid_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_w_reg     <= run_w_next;
            run_v_reg     <= run_v_next;
            start_reg     <= start_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        w_reg          <= w_next;
        proc_idx_reg   <= proc_idx_next;
        min_found_reg  <= min_found_next;
        min_slot_reg   <= min_slot_next;
        min_ent_reg    <= min_ent_next;
        find_found_reg <= find_found_next;
        find_slot_reg  <= find_slot_next;
        find_v_reg     <= find_v_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        wait_found_reg <= wait_found_next;
        err_reg        <= err_next;
        rsp_reg        <= rsp_next;
    end

    // task table
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_SCAN)
        else $error("accepted request did not start a table scan");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.done |-> state_reg == S_DIV)
        else $error("divider finished outside the charge step");

    a_idle_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.running_valid |->
            rsp_data.running_task == 16'd0 && rsp_data.running_vruntime == 64'd0)
        else $error("idle response carries a running task");

    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_EXEC)
        else $error("table write outside the execute step");

endmodule

`default_nettype wire
